// ===== rtl/core/kfrq_pkg.sv =====
// Shared types and constants of the key frequency table.
`timescale 1ns / 1ps

package kfrq_pkg;

    localparam int TableDepthDef = 64;
    localparam int TopKDef       = 10;
    localparam int KEY_W         = 64;
    localparam int CNT_W         = 32;
    localparam int RANK_W        = 6;

    localparam logic REQ_ADD    = 1'b0;
    localparam logic REQ_REPORT = 1'b1;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [2:0] {
        ST_INC    = 3'd0,
        ST_INS    = 3'd1,
        ST_FULL   = 3'd2,
        ST_EMPTY  = 3'd3,
        ST_REPORT = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ADD,
        S_REP,
        S_EMIT
    } t_state;

    typedef struct packed {
        t_status           status;
        logic              entry_valid;
        logic [RANK_W-1:0] rank;
        logic [KEY_W-1:0]  key;
        logic [CNT_W-1:0]  count;
        logic              last;
    } t_result;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == COUNT_MAX) ? v : v + CNT_W'(1);
    endfunction

endpackage

// ===== rtl/core/kfrq_ram.sv =====
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps

module kfrq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/kfrq_engine.sv =====
// Scan sequencer: key lookup, insert, count update and top-K selection.
`timescale 1ns / 1ps

module kfrq_engine import kfrq_pkg::*; #(
    parameter int TABLE_DEPTH = TableDepthDef,
    parameter int TOP_K       = TopKDef,
    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    localparam int UW = $clog2(TABLE_DEPTH + 1),
    localparam int TW = (UW > RANK_W + 1) ? UW : RANK_W + 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_ready,
    input  logic             i_req_type,
    input  logic [KEY_W-1:0] i_key,
    output logic [IW-1:0]    o_rd_addr,
    input  logic [KEY_W-1:0] i_key_rdata,
    input  logic [CNT_W-1:0] i_cnt_rdata,
    output logic             o_key_we,
    output logic             o_cnt_we,
    output logic [IW-1:0]    o_waddr,
    output logic [KEY_W-1:0] o_key_wdata,
    output logic [CNT_W-1:0] o_cnt_wdata,
    output logic             o_res_valid,
    output t_result          o_res,
    input  logic             i_res_ready
);

    t_state            r_state, n_state;
    logic [UW-1:0]     r_used, n_used;
    logic [UW-1:0]     r_iss, n_iss;
    logic              r_rd_vld, n_rd_vld;
    logic [IW-1:0]     r_rd_idx, n_rd_idx;
    logic              r_have, n_have;
    logic [IW-1:0]     r_best_idx, n_best_idx;
    logic [KEY_W-1:0]  r_best_key, n_best_key;
    logic [CNT_W-1:0]  r_best_cnt, n_best_cnt;
    logic [IW-1:0]     r_prev_idx, n_prev_idx;
    logic [CNT_W-1:0]  r_prev_cnt, n_prev_cnt;
    logic [RANK_W-1:0] r_rank, n_rank;
    logic [KEY_W-1:0]  r_key, n_key;
    t_result           r_res, n_res;

    logic          issue_more;
    logic          scan_done;
    logic [TW-1:0] total;
    logic          eligible;
    logic          better;
    logic [CNT_W-1:0] inc_cnt;

    assign issue_more = r_iss < r_used;
    assign scan_done  = !issue_more && !r_rd_vld;
    assign total      = (TW'(r_used) < TW'(TOP_K)) ? TW'(r_used) : TW'(TOP_K);
    assign eligible   = (r_rank == '0) || (i_cnt_rdata < r_prev_cnt) ||
                        ((i_cnt_rdata == r_prev_cnt) && (r_rd_idx > r_prev_idx));
    assign better     = !r_have || (i_cnt_rdata > r_best_cnt);
    assign inc_cnt    = sat_inc(i_cnt_rdata);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_used   <= '0;
            r_iss    <= '0;
            r_rd_vld <= 1'b0;
            r_have   <= 1'b0;
            r_rank   <= '0;
        end else begin
            r_state  <= n_state;
            r_used   <= n_used;
            r_iss    <= n_iss;
            r_rd_vld <= n_rd_vld;
            r_have   <= n_have;
            r_rank   <= n_rank;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx   <= n_rd_idx;
        r_best_idx <= n_best_idx;
        r_best_key <= n_best_key;
        r_best_cnt <= n_best_cnt;
        r_prev_idx <= n_prev_idx;
        r_prev_cnt <= n_prev_cnt;
        r_key      <= n_key;
        r_res      <= n_res;
    end

    always_comb begin
        n_state    = r_state;
        n_used     = r_used;
        n_iss      = r_iss;
        n_rd_vld   = r_rd_vld;
        n_rd_idx   = r_rd_idx;
        n_have     = r_have;
        n_best_idx = r_best_idx;
        n_best_key = r_best_key;
        n_best_cnt = r_best_cnt;
        n_prev_idx = r_prev_idx;
        n_prev_cnt = r_prev_cnt;
        n_rank     = r_rank;
        n_key      = r_key;
        n_res      = r_res;
        o_req_ready = 1'b0;
        o_res_valid = 1'b0;
        o_rd_addr   = r_iss[IW-1:0];
        o_key_we    = 1'b0;
        o_cnt_we    = 1'b0;
        o_waddr     = r_used[IW-1:0];
        o_key_wdata = r_key;
        o_cnt_wdata = CNT_W'(1);

        case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    n_key    = i_key;
                    n_iss    = '0;
                    n_rd_vld = 1'b0;
                    n_have   = 1'b0;
                    n_rank   = '0;
                    if (i_req_type == REQ_REPORT) begin
                        n_state = S_REP;
                    end else if (i_key == '0) begin
                        n_res   = '{ST_EMPTY, 1'b0, '0, i_key, '0, 1'b1};
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_ADD;
                    end
                end
            end
            S_ADD: begin
                n_rd_vld = issue_more;
                n_rd_idx = r_iss[IW-1:0];
                if (issue_more) begin
                    n_iss = r_iss + UW'(1);
                end
                if (r_rd_vld && (i_key_rdata == r_key)) begin
                    o_cnt_we    = 1'b1;
                    o_waddr     = r_rd_idx;
                    o_cnt_wdata = inc_cnt;
                    n_rd_vld    = 1'b0;
                    n_res       = '{ST_INC, 1'b0, '0, r_key, inc_cnt, 1'b1};
                    n_state     = S_EMIT;
                end else if (scan_done) begin
                    if (r_used < UW'(TABLE_DEPTH)) begin
                        o_key_we = 1'b1;
                        o_cnt_we = 1'b1;
                        n_used   = r_used + UW'(1);
                        n_res    = '{ST_INS, 1'b0, '0, r_key, CNT_W'(1), 1'b1};
                    end else begin
                        n_res    = '{ST_FULL, 1'b0, '0, r_key, '0, 1'b1};
                    end
                    n_state = S_EMIT;
                end
            end
            S_REP: begin
                if (total == '0) begin
                    n_res   = '{ST_REPORT, 1'b0, '0, '0, '0, 1'b1};
                    n_state = S_EMIT;
                end else begin
                    n_rd_vld = issue_more;
                    n_rd_idx = r_iss[IW-1:0];
                    if (issue_more) begin
                        n_iss = r_iss + UW'(1);
                    end
                    if (r_rd_vld && eligible && better) begin
                        n_have     = 1'b1;
                        n_best_idx = r_rd_idx;
                        n_best_key = i_key_rdata;
                        n_best_cnt = i_cnt_rdata;
                    end
                    if (scan_done) begin
                        n_res = '{ST_REPORT, 1'b1, r_rank, r_best_key, r_best_cnt,
                                  (TW'(r_rank) + TW'(1)) == total};
                        n_prev_idx = r_best_idx;
                        n_prev_cnt = r_best_cnt;
                        n_rank     = r_rank + RANK_W'(1);
                        n_state    = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_iss    = '0;
                    n_rd_vld = 1'b0;
                    n_have   = 1'b0;
                    n_state  = r_res.last ? S_IDLE : S_REP;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_res = r_res;

endmodule

// ===== rtl/core/key_frequency_table_top_k_unit.sv =====
// Key frequency table with top-K report: memories, sequencer and output stage.
`timescale 1ns / 1ps

// Counts 64-bit keys in a table of TABLE_DEPTH slots held in a key memory and
// a count memory. With N keys stored, an add of a nonzero key walks the key
// memory's read port one slot a cycle until it hits the key or passes the
// last used slot, then updates the count, inserts the key or reports the
// table full. A report gives min(N, TOP_K) beats (one beat with tuser
// entry_valid low on an empty table), each a fresh pass over the memories.
// One request is worked at a time; the output register lets the next request
// in while the last beat waits. No clearing pass follows reset.
module key_frequency_table_top_k_unit import kfrq_pkg::*; #(
    parameter int TABLE_DEPTH = TableDepthDef,
    parameter int TOP_K       = TopKDef
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // key
    input  logic [0:0]   s_tuser,   // req_type
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // rank, key_out, count_out, zero pad
    output logic [3:0]   m_tuser,   // status, entry_valid
    output logic         m_tlast    // last
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [IW-1:0]    rd_addr;
    logic [KEY_W-1:0] key_rdata;
    logic [CNT_W-1:0] cnt_rdata;
    logic             key_we;
    logic             cnt_we;
    logic [IW-1:0]    waddr;
    logic [KEY_W-1:0] key_wdata;
    logic [CNT_W-1:0] cnt_wdata;
    logic             res_valid;
    logic             res_ready;
    t_result          res;

    logic             r_out_vld;
    t_result          r_out;

    kfrq_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_DEPTH)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (waddr),
        .i_wdata (key_wdata),
        .i_raddr (rd_addr),
        .o_rdata (key_rdata)
    );

    kfrq_ram #(.WIDTH(CNT_W), .DEPTH(TABLE_DEPTH)) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (waddr),
        .i_wdata (cnt_wdata),
        .i_raddr (rd_addr),
        .o_rdata (cnt_rdata)
    );

    kfrq_engine #(.TABLE_DEPTH(TABLE_DEPTH), .TOP_K(TOP_K)) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_tvalid),
        .o_req_ready (s_tready),
        .i_req_type  (s_tuser[0]),
        .i_key       (s_tdata),
        .o_rd_addr   (rd_addr),
        .i_key_rdata (key_rdata),
        .i_cnt_rdata (cnt_rdata),
        .o_key_we    (key_we),
        .o_cnt_we    (cnt_we),
        .o_waddr     (waddr),
        .o_key_wdata (key_wdata),
        .o_cnt_wdata (cnt_wdata),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    assign res_ready = !r_out_vld || m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_vld <= 1'b1;
        end else if (m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign m_tvalid = r_out_vld;
    assign m_tdata  = {2'b00, r_out.count, r_out.key, r_out.rank};
    assign m_tuser  = {r_out.entry_valid, r_out.status};
    assign m_tlast  = r_out.last;

endmodule

// ===== rtl/core/kfrq_checker.sv =====
// Port-level checks of the key frequency table, bound to the top level.
`timescale 1ns / 1ps

module kfrq_checker import kfrq_pkg::*; (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [63:0]  s_tdata,
    input logic [0:0]   s_tuser,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [103:0] m_tdata,
    input logic [3:0]   m_tuser,
    input logic         m_tlast
);

    logic [2:0] st;
    assign st = m_tuser[2:0];

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=>
        m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
        else $error("output beat changed while stalled");

    a_status_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (st <= 3'(ST_REPORT)) && (!m_tuser[3] || st == 3'(ST_REPORT)))
        else $error("bad status or entry_valid");

    a_add_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && st != 3'(ST_REPORT) |->
        m_tlast && m_tdata[5:0] == 6'd0 && m_tdata[103:102] == 2'b00)
        else $error("add result not a single beat");

    a_zero_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && (st == 3'(ST_FULL) || st == 3'(ST_EMPTY)) |->
        m_tdata[101:70] == 32'd0)
        else $error("dropped or ignored key carries a count");

    a_report_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && st == 3'(ST_REPORT) && !m_tlast |-> !s_tready)
        else $error("request taken in the middle of a report");

endmodule

bind key_frequency_table_top_k_unit kfrq_checker u_kfrq_checker (.*);

// ===== tb/key_frequency_table_top_k_unit_tb.sv =====
// Self-checking testbench of the key frequency table with top-K report.
`timescale 1ns / 1ps

module key_frequency_table_top_k_unit_tb;
    import kfrq_pkg::*;

    class freq_scoreboard;
        logic [KEY_W-1:0] slot_key [TableDepthDef];
        logic [CNT_W-1:0] slot_count [TableDepthDef];
        int used;
        t_result expected_q[$];
        int mismatches;
        int beats_seen;
        int requests;
        int reports;
        int drops;

        function t_result make_beat(t_status st, logic valid, int rank,
                                    logic [KEY_W-1:0] k, logic [CNT_W-1:0] c, logic last);
            t_result b;
            b.status      = st;
            b.entry_valid = valid;
            b.rank        = RANK_W'(rank);
            b.key         = k;
            b.count       = c;
            b.last        = last;
            return b;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_request(logic req, logic [KEY_W-1:0] k);
            int hit;
            int n_out;
            int best;
            bit picked [TableDepthDef];
            requests++;
            if (req == REQ_REPORT) begin
                reports++;
                n_out = (used < TopKDef) ? used : TopKDef;
                if (n_out == 0)
                    expected_q.push_back(make_beat(ST_REPORT, 1'b0, 0, '0, '0, 1'b1));
                for (int r = 0; r < n_out; r++) begin
                    best = -1;
                    for (int i = 0; i < used; i++)
                        if (!picked[i] && (best < 0 || slot_count[i] > slot_count[best]))
                            best = i;
                    picked[best] = 1'b1;
                    expected_q.push_back(make_beat(ST_REPORT, 1'b1, r, slot_key[best],
                                                   slot_count[best], r == n_out - 1));
                end
            end else if (k == '0) begin
                expected_q.push_back(make_beat(ST_EMPTY, 1'b0, 0, k, '0, 1'b1));
            end else begin
                hit = -1;
                for (int i = 0; i < used; i++)
                    if (slot_key[i] == k)
                        hit = i;
                if (hit >= 0) begin
                    if (slot_count[hit] != COUNT_MAX)
                        slot_count[hit]++;
                    expected_q.push_back(make_beat(ST_INC, 1'b0, 0, k, slot_count[hit], 1'b1));
                end else if (used < TableDepthDef) begin
                    slot_key[used]   = k;
                    slot_count[used] = 1;
                    used++;
                    expected_q.push_back(make_beat(ST_INS, 1'b0, 0, k, 1, 1'b1));
                end else begin
                    drops++;
                    expected_q.push_back(make_beat(ST_FULL, 1'b0, 0, k, '0, 1'b1));
                end
            end
        endfunction

        function void check_beat(t_result got);
            t_result want;
            string bad;
            beats_seen++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: st=%0d key=%h cnt=%0d",
                             got.status, got.key, got.count);
                return;
            end
            want = expected_q.pop_front();
            bad = "";
            if (got.status !== want.status)           bad = {bad, " status"};
            if (got.entry_valid !== want.entry_valid) bad = {bad, " entry_valid"};
            if (got.rank !== want.rank)               bad = {bad, " rank"};
            if (got.key !== want.key)                 bad = {bad, " key_out"};
            if (got.count !== want.count)             bad = {bad, " count_out"};
            if (got.last !== want.last)               bad = {bad, " last"};
            if (bad != "") begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch on%s", bad);
                    $display("  expected st=%0d v=%b rank=%0d key=%h cnt=%0d last=%b",
                             want.status, want.entry_valid, want.rank, want.key,
                             want.count, want.last);
                    $display("  got      st=%0d v=%b rank=%0d key=%h cnt=%0d last=%b",
                             got.status, got.entry_valid, got.rank, got.key,
                             got.count, got.last);
                end
            end
        endfunction
    endclass

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [63:0]  s_tdata = '0;   // key
    logic [0:0]   s_tuser = '0;   // req_type
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;        // rank, key_out, count_out, zero pad
    logic [3:0]   m_tuser;        // status, entry_valid
    logic         m_tlast;

    freq_scoreboard sb = new();
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    logic hold_active = 1'b0;
    event hold_go;
    logic [KEY_W-1:0] key_pool [16];

    key_frequency_table_top_k_unit #(
        .TABLE_DEPTH(TableDepthDef),
        .TOP_K      (TopKDef)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (hold_active) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // hold off the receiver for a long stretch
    initial begin
        @(hold_go);
        hold_active <= 1'b1;
        repeat (400) @(posedge i_clk);
        hold_active <= 1'b0;
    end

    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && m_tvalid && m_tready) begin
            got.status      = t_status'(m_tuser[2:0]);
            got.entry_valid = m_tuser[3];
            got.rank        = m_tdata[RANK_W-1:0];
            got.key         = m_tdata[RANK_W +: KEY_W];
            got.count       = m_tdata[RANK_W+KEY_W +: CNT_W];
            got.last        = m_tlast;
            sb.check_beat(got);
        end
    end

    function automatic logic [KEY_W-1:0] fresh_key();
        return {$urandom, $urandom};
    endfunction

    task automatic send_req(input logic req, input logic [KEY_W-1:0] k);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= k;
        s_tuser  <= req;
        do @(posedge i_clk); while (!s_tready);
        sb.note_request(req, k);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct <= recv_pct;
    endtask

    task automatic run_random(input int n_items);
        for (int i = 0; i < n_items; i++) begin
            int pick;
            pick = $urandom_range(99);
            if (pick < 10)
                send_req(REQ_REPORT, fresh_key());
            else if (pick < 15)
                send_req(REQ_ADD, '0);
            else if (pick < 70)
                send_req(REQ_ADD, key_pool[$urandom_range(15)]);
            else
                send_req(REQ_ADD, fresh_key());
        end
    endtask

    initial begin
        for (int i = 0; i < 16; i++)
            key_pool[i] = fresh_key();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty table, empty key, extreme keys, ties, short report
        set_idling(0, 0);
        send_req(REQ_REPORT, '0);
        send_req(REQ_ADD, '0);
        send_req(REQ_ADD, '1);
        send_req(REQ_ADD, 64'h1);
        send_req(REQ_ADD, 64'h8000_0000_0000_0000);
        send_req(REQ_ADD, 64'h1);
        send_req(REQ_ADD, '1);
        send_req(REQ_ADD, 64'h5555_5555_5555_5555);
        send_req(REQ_ADD, 64'hAAAA_AAAA_AAAA_AAAA);
        send_req(REQ_REPORT, '1);
        send_req(REQ_ADD, 64'h1);
        send_req(REQ_ADD, 64'hAAAA_AAAA_AAAA_AAAA);
        send_req(REQ_REPORT, '0);
        drain_results();

        run_random(12);
        set_idling(74, 0);
        run_random(12);
        set_idling(0, 74);
        run_random(12);
        set_idling(74, 74);
        run_random(12);
        drain_results();

        // back up the output while the sender keeps offering
        set_idling(0, 0);
        -> hold_go;
        for (int i = 0; i < 6; i++)
            send_req(REQ_ADD, key_pool[$urandom_range(15)]);
        drain_results();

        // fill the table, then overflow it
        set_idling(22, 22);
        while (sb.used < TableDepthDef)
            send_req(REQ_ADD, fresh_key());
        for (int i = 0; i < 3; i++)
            send_req(REQ_ADD, fresh_key());
        send_req(REQ_REPORT, '0);
        run_random(5);
        send_req(REQ_REPORT, '1);
        drain_results();
        repeat (100) @(posedge i_clk);

        $display("covered %0d requests (%0d reports, %0d dropped on a full table),",
                 sb.requests, sb.reports, sb.drops);
        $display("%0d result beats checked, %0d keys in table, %0d mismatches",
                 sb.beats_seen, sb.used, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #(64'd40_000_000);
        $display("timeout with %0d results outstanding", sb.pending());
        $display("CHECK FAILED");
        $finish;
    end

endmodule
